FILE: rtl/hfe_pkg.sv
// Shared types, constants and microcode table of the Haar feature evaluator.
package hfe_pkg;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned PC_W    = 5;

  localparam logic [PC_W-1:0] PC_FIRST = 5'd0;
  localparam logic [PC_W-1:0] PC_NULL  = 5'd16;
  localparam logic [PC_W-1:0] PC_WRITE = 5'd17;

  localparam logic [1:0] CORNER_BR = 2'd0;
  localparam logic [1:0] CORNER_BL = 2'd1;
  localparam logic [1:0] CORNER_TR = 2'd2;
  localparam logic [1:0] CORNER_TL = 2'd3;

  localparam logic [1:0] FLOW_STEP      = 2'd0;
  localparam logic [1:0] FLOW_END_TWO   = 2'd1;
  localparam logic [1:0] FLOW_END_THREE = 2'd2;
  localparam logic [1:0] FLOW_END       = 2'd3;

  localparam logic [2:0] KIND_TWO_H   = 3'd0;
  localparam logic [2:0] KIND_TWO_V   = 3'd1;
  localparam logic [2:0] KIND_THREE_H = 3'd2;
  localparam logic [2:0] KIND_THREE_V = 3'd3;
  localparam logic [2:0] KIND_FOUR_D  = 3'd4;

  localparam logic signed [34:0] SUM_MAX = 35'sd8589934590;

  typedef struct packed {
    logic [1:0] rect;
    logic [1:0] corner;
    logic [1:0] flow;
    logic       acc;
    logic       we;
  } ucode_t;

  typedef struct packed {
    logic vld;
    logic we;
    logic acc;
    logic neg;
    logic last;
  } token_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] fx;
    logic [7:0] fy;
    logic [7:0] fw;
    logic [7:0] fh;
    logic [7:0] w2;
    logic [7:0] h2;
    logic [7:0] w3;
    logic [7:0] h3;
    logic [7:0] w23;
    logic [7:0] h23;
  } geom_t;

  typedef struct packed {
    logic [7:0] rx;
    logic [7:0] ry;
    logic [7:0] rw;
    logic [7:0] rh;
    logic       neg;
  } rect_t;

  // Exact floor division by three for any 8-bit value.
  function automatic logic [7:0] div3(input logic [7:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd171;
    return {1'b0, p[15:9]};
  endfunction

  function automatic ucode_t ucode_word(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:    w = '{2'd0, CORNER_BR, FLOW_STEP,      1'b1, 1'b0};
      5'd1:    w = '{2'd0, CORNER_BL, FLOW_STEP,      1'b1, 1'b0};
      5'd2:    w = '{2'd0, CORNER_TR, FLOW_STEP,      1'b1, 1'b0};
      5'd3:    w = '{2'd0, CORNER_TL, FLOW_STEP,      1'b1, 1'b0};
      5'd4:    w = '{2'd1, CORNER_BR, FLOW_STEP,      1'b1, 1'b0};
      5'd5:    w = '{2'd1, CORNER_BL, FLOW_STEP,      1'b1, 1'b0};
      5'd6:    w = '{2'd1, CORNER_TR, FLOW_STEP,      1'b1, 1'b0};
      5'd7:    w = '{2'd1, CORNER_TL, FLOW_END_TWO,   1'b1, 1'b0};
      5'd8:    w = '{2'd2, CORNER_BR, FLOW_STEP,      1'b1, 1'b0};
      5'd9:    w = '{2'd2, CORNER_BL, FLOW_STEP,      1'b1, 1'b0};
      5'd10:   w = '{2'd2, CORNER_TR, FLOW_STEP,      1'b1, 1'b0};
      5'd11:   w = '{2'd2, CORNER_TL, FLOW_END_THREE, 1'b1, 1'b0};
      5'd12:   w = '{2'd3, CORNER_BR, FLOW_STEP,      1'b1, 1'b0};
      5'd13:   w = '{2'd3, CORNER_BL, FLOW_STEP,      1'b1, 1'b0};
      5'd14:   w = '{2'd3, CORNER_TR, FLOW_STEP,      1'b1, 1'b0};
      5'd15:   w = '{2'd3, CORNER_TL, FLOW_END,       1'b1, 1'b0};
      5'd16:   w = '{2'd0, CORNER_BR, FLOW_END,       1'b0, 1'b0};
      5'd17:   w = '{2'd0, CORNER_BR, FLOW_END,       1'b0, 1'b1};
      default: w = '{2'd0, CORNER_BR, FLOW_END,       1'b0, 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic ends_here(input logic [1:0] flow, input logic [2:0] kind);
    logic e;
    case (flow)
      FLOW_END:       e = 1'b1;
      FLOW_END_TWO:   e = (kind == KIND_TWO_H) || (kind == KIND_TWO_V);
      FLOW_END_THREE: e = (kind == KIND_THREE_H) || (kind == KIND_THREE_V);
      default:        e = 1'b0;
    endcase
    return e;
  endfunction

  function automatic rect_t rect_geom(input geom_t g, input logic [1:0] idx);
    rect_t r;
    r = '{g.fx, g.fy, g.fw, g.fh, 1'b0};
    case (g.kind)
      KIND_TWO_H: begin
        r.rw = g.w2;
        case (idx)
          2'd0:    r.rx = g.fx + g.w2;
          default: r.neg = 1'b1;
        endcase
      end
      KIND_TWO_V: begin
        r.rh = g.h2;
        case (idx)
          2'd0: ;
          default: begin
            r.ry  = g.fy + g.h2;
            r.neg = 1'b1;
          end
        endcase
      end
      KIND_THREE_H: begin
        r.rw = g.w3;
        case (idx)
          2'd0: r.rx = g.fx + g.w3;
          2'd1: r.neg = 1'b1;
          default: begin
            r.rx  = g.fx + g.w23;
            r.neg = 1'b1;
          end
        endcase
      end
      KIND_THREE_V: begin
        r.rh = g.h3;
        case (idx)
          2'd0: r.ry = g.fy + g.h3;
          2'd1: r.neg = 1'b1;
          default: begin
            r.ry  = g.fy + g.h23;
            r.neg = 1'b1;
          end
        endcase
      end
      KIND_FOUR_D: begin
        r.rw = g.w2;
        r.rh = g.h2;
        case (idx)
          2'd0: r.rx = g.fx + g.w2;
          2'd1: r.ry = g.fy + g.h2;
          2'd2: begin
            r.rx  = g.fx + g.w2;
            r.ry  = g.fy + g.h2;
            r.neg = 1'b1;
          end
          default: r.neg = 1'b1;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/hfe_ram.sv
// Generic single-port RAM with registered read data.
module hfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/haar_feature_evaluator_top.sv
// Haar-like feature evaluator over an integral image held in a single-port RAM.
//
// Channel   Direction  Transfer condition        Payload
// command   in         start && !busy            op_i, entry_*, feature_*, window_*
// result    out        done_o (one cycle)        feature_sum_o
// config    in         cfg_valid_i && cfg_ready_o cfg_data_i (image_width)
//
// A write holds busy until its entry is written to the RAM. An evaluation with
// n rectangles issues 4n corner reads, one per cycle from the single RAM port.
// Each corner address passes a four-stage wrap pipeline first.
// Reset is asynchronous and active low; the RAM contents are not cleared.
// The result cannot be stalled; busy falls in the cycle the result is shown.
module haar_feature_evaluator_top import hfe_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned ENTRY_BITS  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [11:0]        entry_index_i,
  input  logic [31:0]        entry_value_i,
  input  logic [2:0]         feature_kind_i,
  input  logic [5:0]         feature_x_i,
  input  logic [5:0]         feature_y_i,
  input  logic [6:0]         feature_width_i,
  input  logic [6:0]         feature_height_i,
  input  logic [5:0]         window_x_i,
  input  logic [5:0]         window_y_i,
  output logic               done_o,
  output logic signed [33:0] feature_sum_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i
);

  localparam int unsigned ADDR_W  = $clog2(STORE_DEPTH);
  localparam int unsigned ACC_W   = ENTRY_BITS + 5;
  localparam int unsigned SAT_W   = (ACC_W > 35) ? ACC_W : 35;
  localparam int unsigned EXT_W   = (ENTRY_BITS > 32) ? ENTRY_BITS : 32;
  localparam int unsigned LIN_W   = 18;
  localparam int unsigned U_W     = 17;
  localparam int unsigned RECIP_W = 19;
  localparam int unsigned PROD_W  = U_W + RECIP_W;
  localparam int unsigned SHIFT   = U_W + ADDR_W;
  localparam int unsigned BIAS    = STORE_DEPTH * ((128 + STORE_DEPTH - 1) / STORE_DEPTH);
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(STORE_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic accept;
  logic busy_q, run_q;
  logic [PC_W-1:0] pc_q;
  logic [6:0] image_width_q;
  geom_t geom_q;
  logic [5:0] wx_q, wy_q;
  logic [11:0] index_q;
  logic [ENTRY_BITS-1:0] value_q;
  logic [EXT_W-1:0] value_ext;

  ucode_t cw;
  rect_t rg;
  logic signed [COORD_W-1:0] left, top, right, bottom, row_d, col_d;
  logic corner_en, corner_neg, issue_last;

  token_t s0_d, s0_q, s1_q, s2_q, s3_q, s4_q;
  logic s5_q, done_q, finish;
  logic signed [COORD_W-1:0] row_q, col_q;
  logic signed [LIN_W-1:0] row_ext, col_ext, pitch_ext, lin_prod, lin_d, lin_q;
  logic [LIN_W-1:0] biased;
  logic [U_W-1:0] u_d, u_q, quot, quot_d, rem_full;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [ADDR_W:0] rem_d, rem_q, rem_wrap;
  logic [ADDR_W-1:0] ram_addr;
  logic ram_we;
  logic [ENTRY_BITS-1:0] ram_rdata;

  logic signed [ACC_W-1:0] acc_q, term;
  logic signed [SAT_W-1:0] acc_ext, sum_max_ext;
  logic signed [33:0] feature_sum_q;

  assign accept      = start && !busy_q;
  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;
  assign value_ext   = EXT_W'(entry_value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      image_width_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      geom_q.kind <= feature_kind_i;
      geom_q.fx   <= {2'b0, feature_x_i};
      geom_q.fy   <= {2'b0, feature_y_i};
      geom_q.fw   <= {1'b0, feature_width_i};
      geom_q.fh   <= {1'b0, feature_height_i};
      geom_q.w2   <= {2'b0, feature_width_i[6:1]};
      geom_q.h2   <= {2'b0, feature_height_i[6:1]};
      geom_q.w3   <= div3({1'b0, feature_width_i});
      geom_q.h3   <= div3({1'b0, feature_height_i});
      geom_q.w23  <= div3({feature_width_i, 1'b0});
      geom_q.h23  <= div3({feature_height_i, 1'b0});
      wx_q        <= window_x_i;
      wy_q        <= window_y_i;
      index_q     <= entry_index_i;
      value_q     <= value_ext[ENTRY_BITS-1:0];
    end
  end

  // Sequencer: step through the microcode until a word ends the program.
  assign cw = ucode_word(pc_q);
  assign rg = rect_geom(geom_q, cw.rect);
  assign issue_last = ends_here(cw.flow, geom_q.kind);
  assign finish = (s3_q.vld && s3_q.we) || s5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      run_q  <= 1'b0;
      pc_q   <= PC_FIRST;
    end else if (accept) begin
      busy_q <= 1'b1;
      run_q  <= 1'b1;
      if (!op_i) begin
        pc_q <= PC_WRITE;
      end else if (feature_kind_i > KIND_FOUR_D) begin
        pc_q <= PC_NULL;
      end else begin
        pc_q <= PC_FIRST;
      end
    end else begin
      if (run_q) begin
        if (issue_last) begin
          run_q <= 1'b0;
        end else begin
          pc_q <= pc_q + 1'b1;
        end
      end
      if (finish) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign left   = COORD_W'(wx_q) + COORD_W'(rg.rx);
  assign top    = COORD_W'(wy_q) + COORD_W'(rg.ry);
  assign right  = left + COORD_W'(rg.rw) - COORD_W'(1);
  assign bottom = top + COORD_W'(rg.rh) - COORD_W'(1);

  always_comb begin
    case (cw.corner)
      CORNER_BR: begin
        row_d = bottom;
        col_d = right;
        corner_en = 1'b1;
        corner_neg = 1'b0;
      end
      CORNER_BL: begin
        row_d = bottom;
        col_d = left - COORD_W'(1);
        corner_en = (left != '0);
        corner_neg = 1'b1;
      end
      CORNER_TR: begin
        row_d = top - COORD_W'(1);
        col_d = right;
        corner_en = (top != '0);
        corner_neg = 1'b1;
      end
      default: begin
        row_d = top - COORD_W'(1);
        col_d = left - COORD_W'(1);
        corner_en = (left != '0) && (top != '0);
        corner_neg = 1'b0;
      end
    endcase
  end

  assign s0_d = '{run_q, cw.we, cw.acc && corner_en, corner_neg ^ rg.neg, issue_last};

  // Address pipeline: linear address, reciprocal multiply, remainder, wrap.
  assign row_ext   = LIN_W'(row_q);
  assign col_ext   = LIN_W'(col_q);
  assign pitch_ext = LIN_W'({1'b0, image_width_q});
  assign lin_prod  = row_ext * pitch_ext;
  assign lin_d     = s0_q.we ? LIN_W'(index_q) : lin_prod + col_ext;

  assign biased   = lin_q + LIN_W'(BIAS);
  assign u_d      = biased[U_W-1:0];
  assign prod_d   = PROD_W'(u_d) * PROD_W'(RECIP);

  assign quot     = U_W'(prod_q >> SHIFT);
  assign quot_d   = quot * U_W'(STORE_DEPTH);
  assign rem_full = u_q - quot_d;
  assign rem_d    = rem_full[ADDR_W:0];

  assign rem_wrap = (rem_q >= (ADDR_W+1)'(STORE_DEPTH)) ?
                    rem_q - (ADDR_W+1)'(STORE_DEPTH) : rem_q;
  assign ram_addr = rem_wrap[ADDR_W-1:0];
  assign ram_we   = s3_q.vld && s3_q.we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q   <= '0;
      s1_q   <= '0;
      s2_q   <= '0;
      s3_q   <= '0;
      s4_q   <= '0;
      s5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s0_q   <= s0_d;
      s1_q   <= s0_q;
      s2_q   <= s1_q;
      s3_q   <= s2_q;
      s4_q   <= '{s3_q.vld && !s3_q.we, s3_q.we, s3_q.acc, s3_q.neg, s3_q.last};
      s5_q   <= s4_q.vld && s4_q.last;
      done_q <= s5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    lin_q  <= lin_d;
    u_q    <= u_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  hfe_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(value_q),
    .rdata_o(ram_rdata)
  );

  // Accumulate corner terms, then saturate into the result register.
  assign term = ACC_W'(ram_rdata);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= '0;
    end else if (s4_q.vld && s4_q.acc) begin
      acc_q <= s4_q.neg ? acc_q - term : acc_q + term;
    end
  end

  assign acc_ext     = SAT_W'(acc_q);
  assign sum_max_ext = SAT_W'(SUM_MAX);

  always_ff @(posedge clk_i) begin
    if (s5_q) begin
      if (acc_ext > sum_max_ext) begin
        feature_sum_q <= sum_max_ext[33:0];
      end else if (acc_ext < -sum_max_ext) begin
        feature_sum_q <= -sum_max_ext[33:0];
      end else begin
        feature_sum_q <= acc_ext[33:0];
      end
    end
  end

  assign done_o        = done_q;
  assign feature_sum_o = feature_sum_q;

endmodule

FILE: rtl/hfe_checker.sv
// Port-level assertions for the Haar feature evaluator and their binding.
module hfe_checker import hfe_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               op_i,
  input logic               done_o,
  input logic signed [33:0] feature_sum_o
);

  logic signed [34:0] sum_ext;

  assign sum_ext = 35'(feature_sum_o);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sum_ext <= SUM_MAX) && (sum_ext >= -SUM_MAX))
    else $error("feature sum outside saturation range");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !op_i) |=> !done_o ##1 !done_o ##1 !done_o ##1 !done_o)
    else $error("write command produced a result");

endmodule

bind haar_feature_evaluator_top hfe_checker u_hfe_checker (.*);
